// ===== rtl/pac_pkg.sv =====
// Shared types, codes and constants for the proximity alarm controller.
package pac_pkg;

    localparam int unsigned TimeWidth   = 32;
    localparam int unsigned DistWidth   = 16;
    localparam int unsigned ColourWidth = 3;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDataWidth = 32;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_WATCH = 2'd1,
        MODE_ALARM = 2'd2,
        MODE_TEST  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACT_UPDATE  = 2'd0,
        ACT_ARM     = 2'd1,
        ACT_DISARM  = 2'd2,
        ACT_SELFTEST = 2'd3
    } action_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_COLOUR_A     = 3'd0,
        CFG_COLOUR_B     = 3'd1,
        CFG_FLASH_PERIOD = 3'd2,
        CFG_TRIGGER_DIST = 3'd3,
        CFG_CLEAR_TIMEOUT = 3'd4
    } cfg_index_t;

    localparam logic [ColourWidth-1:0] ColourAReset     = 3'd4;
    localparam logic [ColourWidth-1:0] ColourBReset     = 3'd1;
    localparam logic [TimeWidth-1:0]   FlashPeriodReset = 32'd250;
    localparam logic [DistWidth-1:0]   TriggerReset     = 16'd150;
    localparam logic [TimeWidth-1:0]   ClearTimeoutReset = 32'd3000;
    localparam logic [TimeWidth-1:0]   TestDurationMs   = 32'd3000;
    localparam logic [ColourWidth-1:0] LampWhite        = 3'd7;
    localparam logic [ColourWidth-1:0] LampDark         = 3'd0;

    typedef struct packed {
        logic [1:0]           action;
        logic [TimeWidth-1:0] now_ms;
        logic [DistWidth-1:0] distance_mm;
    } req_t;

    typedef struct packed {
        logic                   buzzer_on;
        logic [ColourWidth-1:0] lamp_colour;
        logic [1:0]             mode;
    } result_t;

    typedef struct packed {
        logic                    we;
        logic [CfgIdxWidth-1:0]  index;
        logic [CfgDataWidth-1:0] wdata;
    } cfg_wr_t;

endpackage

// ===== rtl/pac_core.sv =====
// Alarm state registers, configuration registers and the per-request update logic.
module pac_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  pac_pkg::req_t    req,
    input  pac_pkg::cfg_wr_t cfg,
    output pac_pkg::result_t result
);

    logic [pac_pkg::ColourWidth-1:0] colour_a_reg;
    logic [pac_pkg::ColourWidth-1:0] colour_b_reg;
    logic [pac_pkg::TimeWidth-1:0]   flash_period_reg;
    logic [pac_pkg::DistWidth-1:0]   trigger_reg;
    logic [pac_pkg::TimeWidth-1:0]   clear_timeout_reg;

    pac_pkg::mode_t                  mode_reg, mode_next;
    logic [pac_pkg::TimeWidth-1:0]   last_time_reg, last_time_next;
    logic [pac_pkg::TimeWidth-1:0]   flash_time_reg, flash_time_next;
    logic [pac_pkg::TimeWidth-1:0]   alarm_start_reg, alarm_start_next;
    logic [pac_pkg::TimeWidth-1:0]   test_start_reg, test_start_next;
    logic                            phase_reg, phase_next;
    logic                            arm_pending_reg, arm_pending_next;
    logic                            disarm_pending_reg, disarm_pending_next;
    logic                            buzzer_reg, buzzer_next;
    logic [pac_pkg::ColourWidth-1:0] lamp_reg, lamp_next;

    logic [pac_pkg::TimeWidth-1:0]   since_flash;
    logic [pac_pkg::TimeWidth-1:0]   since_alarm;
    logic [pac_pkg::TimeWidth-1:0]   since_test;
    logic                            is_near;
    pac_pkg::mode_t                  mode_applied;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colour_a_reg      <= pac_pkg::ColourAReset;
            colour_b_reg      <= pac_pkg::ColourBReset;
            flash_period_reg  <= pac_pkg::FlashPeriodReset;
            trigger_reg       <= pac_pkg::TriggerReset;
            clear_timeout_reg <= pac_pkg::ClearTimeoutReset;
        end else if (cfg.we) begin
            case (cfg.index)
                pac_pkg::CFG_COLOUR_A: begin
                    colour_a_reg <= cfg.wdata[pac_pkg::ColourWidth-1:0];
                end
                pac_pkg::CFG_COLOUR_B: begin
                    colour_b_reg <= cfg.wdata[pac_pkg::ColourWidth-1:0];
                end
                pac_pkg::CFG_FLASH_PERIOD: begin
                    flash_period_reg <= cfg.wdata[pac_pkg::TimeWidth-1:0];
                end
                pac_pkg::CFG_TRIGGER_DIST: begin
                    trigger_reg <= cfg.wdata[pac_pkg::DistWidth-1:0];
                end
                pac_pkg::CFG_CLEAR_TIMEOUT: begin
                    clear_timeout_reg <= cfg.wdata[pac_pkg::TimeWidth-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign since_flash = req.now_ms - flash_time_reg;
    assign since_alarm = req.now_ms - alarm_start_reg;
    assign since_test  = req.now_ms - test_start_reg;
    assign is_near     = req.distance_mm < trigger_reg;

    // Pending requests are applied first; a disarm overrides an arm.
    always_comb begin
        if (disarm_pending_reg) begin
            mode_applied = pac_pkg::MODE_OFF;
        end else if (arm_pending_reg) begin
            mode_applied = pac_pkg::MODE_WATCH;
        end else begin
            mode_applied = mode_reg;
        end
    end

    always_comb begin
        mode_next           = mode_reg;
        last_time_next      = last_time_reg;
        flash_time_next     = flash_time_reg;
        alarm_start_next    = alarm_start_reg;
        test_start_next     = test_start_reg;
        phase_next          = phase_reg;
        arm_pending_next    = arm_pending_reg;
        disarm_pending_next = disarm_pending_reg;
        buzzer_next         = buzzer_reg;
        lamp_next           = lamp_reg;
        case (pac_pkg::action_t'(req.action))
            pac_pkg::ACT_UPDATE: begin
                last_time_next      = req.now_ms;
                arm_pending_next    = 1'b0;
                disarm_pending_next = 1'b0;
                mode_next           = mode_applied;
                case (mode_applied)
                    pac_pkg::MODE_OFF: begin
                        buzzer_next = 1'b0;
                        lamp_next   = pac_pkg::LampDark;
                    end
                    pac_pkg::MODE_WATCH: begin
                        if (is_near) begin
                            alarm_start_next = req.now_ms;
                            mode_next        = pac_pkg::MODE_ALARM;
                            buzzer_next      = 1'b1;
                        end else begin
                            buzzer_next = 1'b0;
                            lamp_next   = pac_pkg::LampDark;
                        end
                    end
                    pac_pkg::MODE_ALARM: begin
                        if (since_flash >= flash_period_reg) begin
                            flash_time_next = req.now_ms;
                            phase_next      = !phase_reg;
                            lamp_next       = phase_reg ? colour_b_reg : colour_a_reg;
                        end
                        if (!is_near && since_alarm >= clear_timeout_reg) begin
                            mode_next   = pac_pkg::MODE_WATCH;
                            buzzer_next = 1'b0;
                            lamp_next   = pac_pkg::LampDark;
                        end
                    end
                    default: begin
                        if (since_test >= pac_pkg::TestDurationMs) begin
                            mode_next   = pac_pkg::MODE_OFF;
                            buzzer_next = 1'b0;
                            lamp_next   = pac_pkg::LampDark;
                        end
                    end
                endcase
            end
            pac_pkg::ACT_ARM: begin
                arm_pending_next = 1'b1;
            end
            pac_pkg::ACT_DISARM: begin
                disarm_pending_next = 1'b1;
            end
            default: begin
                mode_next       = pac_pkg::MODE_TEST;
                test_start_next = last_time_reg;
                buzzer_next     = 1'b1;
                lamp_next       = pac_pkg::LampWhite;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= pac_pkg::MODE_OFF;
            last_time_reg      <= '0;
            flash_time_reg     <= '0;
            alarm_start_reg    <= '0;
            test_start_reg     <= '0;
            phase_reg          <= 1'b0;
            arm_pending_reg    <= 1'b0;
            disarm_pending_reg <= 1'b0;
            buzzer_reg         <= 1'b0;
            lamp_reg           <= pac_pkg::LampDark;
        end else if (step_en) begin
            mode_reg           <= mode_next;
            last_time_reg      <= last_time_next;
            flash_time_reg     <= flash_time_next;
            alarm_start_reg    <= alarm_start_next;
            test_start_reg     <= test_start_next;
            phase_reg          <= phase_next;
            arm_pending_reg    <= arm_pending_next;
            disarm_pending_reg <= disarm_pending_next;
            buzzer_reg         <= buzzer_next;
            lamp_reg           <= lamp_next;
        end
    end

    assign result.buzzer_on   = buzzer_next;
    assign result.lamp_colour = lamp_next;
    assign result.mode        = mode_next;

    // An update always consumes both latched requests.
    a_update_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && req.action == pac_pkg::ACT_UPDATE
        |=> !arm_pending_reg && !disarm_pending_reg)
        else $error("pending request survived an update");

    // Whenever the block is off or watching, both outputs are dark.
    a_quiet_modes_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == pac_pkg::MODE_OFF || mode_reg == pac_pkg::MODE_WATCH
        |-> !buzzer_reg && lamp_reg == pac_pkg::LampDark)
        else $error("buzzer or lamp lit while off or watching");

    // The buzzer sounds throughout an alarm or a self-test.
    a_buzzer_active: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == pac_pkg::MODE_ALARM || mode_reg == pac_pkg::MODE_TEST |-> buzzer_reg)
        else $error("buzzer silent during alarm or self-test");

    // State only moves when a request is processed.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(mode_reg) && $stable(lamp_reg) && $stable(phase_reg))
        else $error("alarm state changed without a request");

endmodule

// ===== rtl/proximity_alarm_controller.sv =====
// Top level of the proximity alarm controller: request register, core and result register.
// The controller takes one request per clock cycle while m_ready stays high and returns one
// result per request, in order; a request accepted on s_ready is captured in the request
// register, which feeds the core, and the core's update is captured in the result register,
// which drives m_valid. One request per cycle is sustained because the update of the alarm
// state, the only loop in the design, is combinational. While a result waits for m_ready the
// request register holds its request, and once both registers are full s_ready follows
// m_ready in the same cycle so that no request is dropped. Configuration writes take effect
// at once and are meant to be made while no request is in flight.
module proximity_alarm_controller (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  pac_pkg::req_t                         s_req,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output pac_pkg::result_t                      m_result,
    input  logic                                  cfg_we,
    input  logic [pac_pkg::CfgIdxWidth-1:0]       cfg_index,
    input  logic [pac_pkg::CfgDataWidth-1:0]      cfg_wdata
);

    logic             in_valid_reg;
    pac_pkg::req_t    in_req_reg;
    logic             out_valid_reg;
    pac_pkg::result_t out_result_reg;
    pac_pkg::result_t core_result;
    pac_pkg::cfg_wr_t cfg_wr;
    logic             advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign cfg_wr.we    = cfg_we;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.wdata = cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= s_req;
        end
    end

    pac_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .req     (in_req_reg),
        .cfg     (cfg_wr),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

endmodule
